/* hw/rtl/epdm_pkg.sv */
// Shared types, widths, register codes and reset values for the echo ranging block.
package epdm_pkg;

    // Width of the saturating echo duration count.
    localparam int COUNT_WIDTH = 16;

    localparam int SETTLE_W  = 16;
    localparam int TRIGGER_W = 20;
    localparam int PRESCALE_W = 16;
    localparam int SCALE_W   = 24;
    localparam int DIST_W    = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Product of count and scale, and the same value after the Q16 to Q8 shift.
    localparam int PROD_W = COUNT_WIDTH + SCALE_W;
    localparam int RAW_W  = PROD_W - 8;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CM_PER_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT     = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [SETTLE_W-1:0]   SETTLE_RST   = 16'd320;
    localparam logic [TRIGGER_W-1:0]  TRIGGER_RST  = 20'd192000;
    localparam logic [PRESCALE_W-1:0] TPC_RST      = 16'd500;
    localparam logic [SCALE_W-1:0]    CM_RST       = 24'd34816;
    localparam logic [DIST_W-1:0]     LIMIT_RST    = 20'd102400;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SETTLE_A = 3'd1,
        PH_TRIG     = 3'd2,
        PH_SETTLE_B = 3'd3,
        PH_WAIT     = 3'd4,
        PH_COUNT    = 3'd5
    } phase_t;

    // Per-tick status leaving the sequencer toward the scaling pipeline.
    typedef struct packed {
        logic                   trigger;
        logic                   busy;
        logic                   done;
        logic [COUNT_WIDTH-1:0] count;
    } seq_res_t;

endpackage

/* hw/rtl/echo_pulse_distance_meter_core.sv */
// Top level of the ultrasonic echo ranging block: configuration registers and wiring.
//
// Each input item is one base-clock tick. It carries a start command bit and the sampled
// echo level, and it produces exactly one result item: trigger pin level, busy, done, an
// in-range flag and the distance in Q8 centimetres (zero unless done is set).
// The input channel (in_valid/in_ready) and the output channel (out_valid/out_ready) use a
// valid/ready handshake. While the receiver keeps out_ready high, an item can be accepted
// in every cycle, so the sustained rate is one item per clock. The sequencer state advances
// in the cycle the item is accepted; the result then passes a stage register, the count
// times scale multiply stage and the compare and saturation stage, and out_valid rises
// once the compare and saturation stage holds it.
// When the receiver stalls, the three stages fill up and in_ready drops only once all of
// them hold an item; no result is lost or repeated. Ready is chained combinationally back
// through the stages, so a stage that empties can be refilled in the same cycle.
// The configuration channel (cfg_valid/cfg_ready) is always ready and writes the register
// chosen by cfg_index from cfg_data; unknown indexes are ignored. Registers are meant to be
// written while the block is idle.
// Reset is asynchronous and active low. It returns the sequencer to idle, clears its
// counters, empties the pipeline and loads the default configuration values.
module echo_pulse_distance_meter_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 command,
    input  logic                                 echo_level,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 trigger_level,
    output logic                                 busy_res,
    output logic                                 done_res,
    output logic                                 in_range,
    output logic [epdm_pkg::DIST_W-1:0]          distance_q8,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [epdm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [epdm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [epdm_pkg::SETTLE_W-1:0]      settle_reg;
    logic [epdm_pkg::TRIGGER_W-1:0]     trigger_reg;
    logic [epdm_pkg::PRESCALE_W-1:0]    tpc_reg;
    logic [epdm_pkg::SCALE_W-1:0]       cm_reg;
    logic [epdm_pkg::DIST_W-1:0]        limit_reg;

    logic                               step;
    epdm_pkg::seq_res_t                 seq_res;

    // The register file can take a write in every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg  <= epdm_pkg::SETTLE_RST;
            trigger_reg <= epdm_pkg::TRIGGER_RST;
            tpc_reg     <= epdm_pkg::TPC_RST;
            cm_reg      <= epdm_pkg::CM_RST;
            limit_reg   <= epdm_pkg::LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                epdm_pkg::CFG_SETTLE_TICKS:
                    settle_reg <= cfg_data[epdm_pkg::SETTLE_W-1:0];
                epdm_pkg::CFG_TRIGGER_TICKS:
                    trigger_reg <= cfg_data[epdm_pkg::TRIGGER_W-1:0];
                epdm_pkg::CFG_TICKS_PER_COUNT:
                    tpc_reg <= cfg_data[epdm_pkg::PRESCALE_W-1:0];
                epdm_pkg::CFG_CM_PER_COUNT:
                    cm_reg <= cfg_data[epdm_pkg::SCALE_W-1:0];
                epdm_pkg::CFG_RANGE_LIMIT:
                    limit_reg <= cfg_data[epdm_pkg::DIST_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The sequencer moves one tick for every accepted item.
    assign step = in_valid && in_ready;

    epdm_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .command         (command),
        .echo_level      (echo_level),
        .settle_ticks    (settle_reg),
        .trigger_ticks   (trigger_reg),
        .ticks_per_count (tpc_reg),
        .res             (seq_res)
    );

    epdm_scale u_scale (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_res           (seq_res),
        .cm_per_count_q16 (cm_reg),
        .range_limit_q8   (limit_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .trigger_level    (trigger_level),
        .busy_res         (busy_res),
        .done_res         (done_res),
        .in_range         (in_range),
        .distance_q8      (distance_q8)
    );

endmodule

/* hw/rtl/epdm_seq.sv */
// Measurement sequencer: trigger phases, echo wait and prescaled echo counting.
module epdm_seq (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step,
    input  logic                                 command,
    input  logic                                 echo_level,
    input  logic [epdm_pkg::SETTLE_W-1:0]        settle_ticks,
    input  logic [epdm_pkg::TRIGGER_W-1:0]       trigger_ticks,
    input  logic [epdm_pkg::PRESCALE_W-1:0]      ticks_per_count,
    output epdm_pkg::seq_res_t                   res
);

    epdm_pkg::phase_t                          phase_reg, phase_next;
    logic [epdm_pkg::TRIGGER_W-1:0]            ticks_reg, ticks_next;
    logic [epdm_pkg::PRESCALE_W-1:0]           pre_reg, pre_next;
    logic [epdm_pkg::COUNT_WIDTH-1:0]          cnt_reg, cnt_next;

    logic [epdm_pkg::TRIGGER_W-1:0]            ticks_inc;
    logic [epdm_pkg::TRIGGER_W-1:0]            limit;
    logic [epdm_pkg::PRESCALE_W-1:0]           pre_inc;
    logic                                      done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= epdm_pkg::PH_IDLE;
            ticks_reg <= '0;
            pre_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
            pre_reg   <= pre_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign ticks_inc = ticks_reg + 1'b1;
    assign pre_inc   = pre_reg + 1'b1;
    assign limit     = (phase_reg == epdm_pkg::PH_TRIG) ? trigger_ticks
                     : epdm_pkg::TRIGGER_W'(settle_ticks);

    always_comb
    begin
        phase_next = phase_reg;
        ticks_next = ticks_reg;
        pre_next   = pre_reg;
        cnt_next   = cnt_reg;
        done       = 1'b0;
        case (phase_reg)
            epdm_pkg::PH_SETTLE_A,
            epdm_pkg::PH_TRIG,
            epdm_pkg::PH_SETTLE_B:
            begin
                // A limit of zero ends the phase on its first tick, like a limit of one.
                if (ticks_inc >= limit)
                begin
                    ticks_next = '0;
                    case (phase_reg)
                        epdm_pkg::PH_SETTLE_A: phase_next = epdm_pkg::PH_TRIG;
                        epdm_pkg::PH_TRIG:     phase_next = epdm_pkg::PH_SETTLE_B;
                        default:               phase_next = epdm_pkg::PH_WAIT;
                    endcase
                end
                else
                begin
                    ticks_next = ticks_inc;
                end
            end
            epdm_pkg::PH_WAIT:
            begin
                if (echo_level)
                begin
                    pre_next   = '0;
                    cnt_next   = '0;
                    phase_next = epdm_pkg::PH_COUNT;
                end
            end
            epdm_pkg::PH_COUNT:
            begin
                if (echo_level)
                begin
                    if (pre_inc >= ticks_per_count)
                    begin
                        pre_next = '0;
                        if (cnt_reg != epdm_pkg::COUNT_MAX)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        pre_next = pre_inc;
                    end
                end
                else
                begin
                    done       = 1'b1;
                    phase_next = epdm_pkg::PH_IDLE;
                    ticks_next = '0;
                end
            end
            default:
            begin
                phase_next = epdm_pkg::PH_IDLE;
                if (command)
                begin
                    phase_next = epdm_pkg::PH_SETTLE_A;
                    ticks_next = '0;
                end
            end
        endcase
    end

    // The count does not change on the tick that echo falls, so the stored value is final.
    assign res.trigger = (phase_next == epdm_pkg::PH_TRIG);
    assign res.busy    = (phase_next != epdm_pkg::PH_IDLE);
    assign res.done    = done;
    assign res.count   = cnt_reg;

endmodule

/* hw/rtl/epdm_scale.sv */
// Result pipeline: count to distance multiply, range compare, saturation and output register.
module epdm_scale (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  epdm_pkg::seq_res_t                in_res,
    input  logic [epdm_pkg::SCALE_W-1:0]      cm_per_count_q16,
    input  logic [epdm_pkg::DIST_W-1:0]       range_limit_q8,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              trigger_level,
    output logic                              busy_res,
    output logic                              done_res,
    output logic                              in_range,
    output logic [epdm_pkg::DIST_W-1:0]       distance_q8
);

    logic                               v1_reg, v2_reg, v3_reg;
    logic                               rdy1, rdy2, rdy3;

    epdm_pkg::seq_res_t                 s1_reg;

    logic                               trig2_reg, busy2_reg, done2_reg;
    logic [epdm_pkg::PROD_W-1:0]        prod_reg, prod_next;

    logic                               trig3_reg, busy3_reg, done3_reg;
    logic                               in_range_reg, in_range_next;
    logic [epdm_pkg::DIST_W-1:0]        dist_reg, dist_next;

    logic [epdm_pkg::RAW_W-1:0]         raw;

    // Each stage loads when it is empty or when its contents move on this cycle.
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign prod_next = epdm_pkg::PROD_W'(s1_reg.count) * epdm_pkg::PROD_W'(cm_per_count_q16);

    assign raw = prod_reg[epdm_pkg::PROD_W-1:8];

    always_comb
    begin
        in_range_next = 1'b0;
        dist_next     = '0;
        if (done2_reg)
        begin
            in_range_next = (raw < epdm_pkg::RAW_W'(range_limit_q8));
            if (raw > epdm_pkg::RAW_W'(epdm_pkg::DIST_MAX))
            begin
                dist_next = epdm_pkg::DIST_MAX;
            end
            else
            begin
                dist_next = raw[epdm_pkg::DIST_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy1)
        begin
            s1_reg <= in_res;
        end
        if (v1_reg && rdy2)
        begin
            trig2_reg <= s1_reg.trigger;
            busy2_reg <= s1_reg.busy;
            done2_reg <= s1_reg.done;
            prod_reg  <= prod_next;
        end
        if (v2_reg && rdy3)
        begin
            trig3_reg    <= trig2_reg;
            busy3_reg    <= busy2_reg;
            done3_reg    <= done2_reg;
            in_range_reg <= in_range_next;
            dist_reg     <= dist_next;
        end
    end

    assign out_valid     = v3_reg;
    assign trigger_level = trig3_reg;
    assign busy_res      = busy3_reg;
    assign done_res      = done3_reg;
    assign in_range      = in_range_reg;
    assign distance_q8   = dist_reg;

endmodule
